@@ sv/rpn_stack_evaluator_unit_defines.svh @@
// Assertion macros for the RPN stack evaluator.
// Used by files that include this header; expects clk and arst_n in scope.
`ifndef RPN_STACK_EVALUATOR_UNIT_DEFINES_SVH
`define RPN_STACK_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/rse_pkg.sv @@
// Shared types, constants and helpers for the RPN stack evaluator.
// No dependencies; every other file of the block but the defines header imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned OPCODE_W        = 3;
	localparam int unsigned STATUS_W        = 2;
	localparam int unsigned CNT_W           = $clog2(DATA_W);
	localparam int unsigned STACK_DEPTH_DEF = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_OVERFLOW  = 2'd2,
		STS_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic [1:0] {
		AP_IDLE,
		AP_RUN,
		AP_FIX,
		AP_DONE
	} alu_phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_B,
		S_RD_A,
		S_ALU,
		S_CHK,
		S_RD_TOP,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

	function automatic alu_op_t to_alu_op(input logic [OPCODE_W-1:0] opcode);
		alu_op_t op;
		case (opcode)
			OP_SUB:  op = ALU_SUB;
			OP_MUL:  op = ALU_MUL;
			OP_DIV:  op = ALU_DIV;
			default: op = ALU_ADD;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

@@ sv/rse_ifs.sv @@
// Valid/ready channel interfaces for tokens in and results out.
// Depends on rse_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rse_tok_if import rse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OPCODE_W-1:0]      opcode;
	logic signed [DATA_W-1:0] number_value;
	logic                     end_of_expression;

	modport source(output valid, opcode, number_value, end_of_expression, input ready);
	modport sink(input valid, opcode, number_value, end_of_expression, output ready);
endinterface

interface rse_res_if import rse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic [STATUS_W-1:0]      status;

	modport source(output valid, result_value, status, input ready);
	modport sink(input valid, result_value, status, output ready);
endinterface

`default_nettype wire

@@ sv/rse_stack.sv @@
// Operand stack storage: one write port and one read port with registered data.
// Depends on rse_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module rse_stack import rse_pkg::*; #(
	parameter int unsigned DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ sv/rse_alu.sv @@
// Shared arithmetic unit: add and subtract in one step, shift-add multiply
// and restoring divide one bit per cycle over one shared adder. Uses rse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rse_alu import rse_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alu_req_t          req,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	output      alu_rsp_t          rsp
);

	alu_phase_t        phase_q, phase_d;
	alu_op_t           op_q, op_d;
	logic              neg_q, neg_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [DATA_W-1:0] acc_q, acc_d;
	logic [DATA_W-1:0] q_q, q_d;
	logic [DATA_W-1:0] m_q, m_d;

	logic [DATA_W:0]   add_x, add_y;
	logic              add_ci;
	logic [DATA_W+1:0] sum;

	function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? (~x + 1'b1) : x;
	endfunction

	always_comb begin
		add_x  = '0;
		add_y  = '0;
		add_ci = 1'b0;
		case (phase_q)
			AP_IDLE: begin
				add_x  = {1'b0, a};
				add_y  = (req.op == ALU_SUB) ? {1'b1, ~b} : {1'b0, b};
				add_ci = (req.op == ALU_SUB);
			end
			AP_RUN: begin
				if (op_q == ALU_MUL) begin
					add_x = {1'b0, acc_q};
					add_y = q_q[0] ? {1'b0, m_q} : '0;
				end else begin
					add_x  = {acc_q, q_q[DATA_W-1]};
					add_y  = {1'b1, ~m_q};
					add_ci = 1'b1;
				end
			end
			AP_FIX: begin
				add_y  = {1'b1, ~q_q};
				add_ci = 1'b1;
			end
			default: begin
				add_x = '0;
			end
		endcase
	end

	assign sum = {1'b0, add_x} + {1'b0, add_y} + {{(DATA_W+1){1'b0}}, add_ci};

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		neg_d   = neg_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		q_d     = q_q;
		m_d     = m_q;
		case (phase_q)
			AP_IDLE: begin
				if (req.start) begin
					op_d  = req.op;
					cnt_d = '0;
					neg_d = a[DATA_W-1] ^ b[DATA_W-1];
					case (req.op)
						ALU_ADD, ALU_SUB: begin
							acc_d   = sum[DATA_W-1:0];
							phase_d = AP_DONE;
						end
						ALU_MUL: begin
							acc_d   = '0;
							q_d     = a;
							m_d     = b;
							phase_d = AP_RUN;
						end
						default: begin
							if (b == '0) begin
								q_d     = '1;
								phase_d = AP_DONE;
							end else begin
								acc_d   = '0;
								q_d     = mag(a);
								m_d     = mag(b);
								phase_d = AP_RUN;
							end
						end
					endcase
				end
			end
			AP_RUN: begin
				cnt_d = cnt_q + 1'b1;
				if (op_q == ALU_MUL) begin
					acc_d = sum[DATA_W-1:0];
					q_d   = {1'b0, q_q[DATA_W-1:1]};
					m_d   = {m_q[DATA_W-2:0], 1'b0};
				end else if (sum[DATA_W+1]) begin
					acc_d = sum[DATA_W-1:0];
					q_d   = {q_q[DATA_W-2:0], 1'b1};
				end else begin
					acc_d = {acc_q[DATA_W-2:0], q_q[DATA_W-1]};
					q_d   = {q_q[DATA_W-2:0], 1'b0};
				end
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					phase_d = (op_q == ALU_DIV && neg_q) ? AP_FIX : AP_DONE;
				end
			end
			AP_FIX: begin
				q_d     = sum[DATA_W-1:0];
				phase_d = AP_DONE;
			end
			default: begin
				phase_d = AP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= AP_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		neg_q <= neg_d;
		cnt_q <= cnt_d;
		acc_q <= acc_d;
		q_q   <= q_d;
		m_q   <= m_d;
	end

	assign rsp.done   = (phase_q == AP_DONE);
	assign rsp.result = (op_q == ALU_DIV) ? q_q : acc_q;

endmodule

`default_nettype wire

@@ sv/rpn_stack_evaluator_unit.sv @@
// Integer RPN evaluator: token sequencer, operand stack and shared ALU.
// Depends on rse_pkg, rse_ifs, rse_stack, rse_alu and the defines header.
//
// Tokens arrive on the tok channel (opcode, number_value, end_of_expression)
// and one result per expression leaves on the res channel (result_value,
// status) when the token marked end_of_expression has been processed.
// The block takes one token at a time; tok.ready is high only while idle.
// A push or an ignored token goes straight to the check state; an arithmetic
// token reads both operands, runs the ALU and writes back; the shift-add multiplier
// and the restoring divider retire one bit per cycle through one adder.
// A final token then reads the stack top and loads the output register,
// or only loads it when it reports an error or an empty stack. The result sits
// in an output register; while the receiver stalls, the block still takes
// tokens until the next final token, which waits until the pending result
// is taken.
// Reset empties the stack and clears any error and any pending result;
// no clearing pass is needed. After each result the stack is empty again.
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_stack_evaluator_unit_defines.svh"

module rpn_stack_evaluator_unit import rse_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rse_tok_if.sink   tok,
	rse_res_if.source res
);

	localparam int unsigned AW  = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

	state_t            state_q, state_d;
	logic [SPW-1:0]    sp_q, sp_d;
	status_t           err_q, err_d;
	logic              res_valid_q, res_valid_d;
	logic [DATA_W-1:0] res_value_q;
	status_t           res_status_q;
	logic              last_q, last_d;
	alu_op_t           aop_q, aop_d;
	logic [DATA_W-1:0] b_q, b_d;
	logic [DATA_W-1:0] fin_value_q, fin_value_d;
	status_t           fin_status_q, fin_status_d;
	logic              emit_load;

	logic [SPW-1:0]    sp_m1, sp_m2;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);

	rse_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	rse_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (mem_rdata),
		.b     (b_q),
		.rsp   (alu_rsp)
	);

	always_comb begin
		state_d      = state_q;
		sp_d         = sp_q;
		err_d        = err_q;
		last_d       = last_q;
		aop_d        = aop_q;
		b_d          = b_q;
		fin_value_d  = fin_value_q;
		fin_status_d = fin_status_q;
		emit_load    = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = sp_q[AW-1:0];
		mem_wdata    = tok.number_value;
		mem_re       = 1'b0;
		mem_raddr    = sp_m1[AW-1:0];
		alu_req      = '{start: 1'b0, op: aop_q};
		case (state_q)
			S_IDLE: begin
				if (tok.valid) begin
					last_d  = tok.end_of_expression;
					aop_d   = to_alu_op(tok.opcode);
					state_d = S_CHK;
					if (err_q == STS_OK) begin
						case (tok.opcode)
							OP_PUSH: begin
								if (sp_q >= SPW'(STACK_DEPTH)) begin
									err_d = STS_OVERFLOW;
								end else begin
									mem_we = 1'b1;
									sp_d   = sp_q + SPW'(1);
								end
							end
							OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
								if (sp_q < SPW'(2)) begin
									err_d = STS_UNDERFLOW;
								end else begin
									mem_re  = 1'b1;
									state_d = S_RD_B;
								end
							end
							default: begin
								state_d = S_CHK;
							end
						endcase
					end
				end
			end
			S_RD_B: begin
				b_d       = mem_rdata;
				mem_re    = 1'b1;
				mem_raddr = sp_m2[AW-1:0];
				state_d   = S_RD_A;
			end
			S_RD_A: begin
				alu_req.start = 1'b1;
				state_d       = S_ALU;
			end
			S_ALU: begin
				if (alu_rsp.done) begin
					mem_we    = 1'b1;
					mem_waddr = sp_m2[AW-1:0];
					mem_wdata = alu_rsp.result;
					sp_d      = sp_m1;
					state_d   = S_CHK;
				end
			end
			S_CHK: begin
				if (!last_q) begin
					state_d = S_IDLE;
				end else if (err_q != STS_OK) begin
					fin_value_d  = '0;
					fin_status_d = err_q;
					state_d      = S_EMIT;
				end else if (sp_q == '0) begin
					fin_value_d  = '0;
					fin_status_d = STS_EMPTY;
					state_d      = S_EMIT;
				end else begin
					mem_re  = 1'b1;
					state_d = S_RD_TOP;
				end
			end
			S_RD_TOP: begin
				fin_value_d  = mem_rdata;
				fin_status_d = STS_OK;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!res_valid_q || res.ready) begin
					emit_load = 1'b1;
					sp_d      = '0;
					err_d     = STS_OK;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (emit_load) begin
			res_valid_d = 1'b1;
		end else if (res.ready) begin
			res_valid_d = 1'b0;
		end else begin
			res_valid_d = res_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			err_q       <= STS_OK;
			res_valid_q <= 1'b0;
		end else begin
			sp_q        <= sp_d;
			err_q       <= err_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q       <= last_d;
		aop_q        <= aop_d;
		b_q          <= b_d;
		fin_value_q  <= fin_value_d;
		fin_status_q <= fin_status_d;
		if (emit_load) begin
			res_value_q  <= fin_value_q;
			res_status_q <= fin_status_q;
		end
	end

	assign tok.ready        = (state_q == S_IDLE);
	assign res.valid        = res_valid_q;
	assign res.result_value = res_value_q;
	assign res.status       = res_status_q;

	`RSE_ASSERT_IMPL(a_sp_in_range, 1'b1, sp_q <= SPW'(STACK_DEPTH), "Stack pointer is beyond the depth.")
	`RSE_ASSERT_IMPL(a_no_write_on_error, err_q != STS_OK, !mem_we, "Stack written with an error pending.")
	`RSE_ASSERT_IMPL(a_error_value_zero, res.valid && res.status != STS_OK, res.result_value == '0, "Error result carries a value.")
	`RSE_ASSERT_IMPL(a_alu_done_expected, alu_rsp.done, state_q == S_ALU, "Arithmetic unit finished outside its wait.")
	`RSE_ASSERT_NEXT(a_clear_after_emit, emit_load, sp_q == '0 && err_q == STS_OK, "Expression state not cleared.")

endmodule

`default_nettype wire

@@ tb/rpn_stack_evaluator_unit_tb.sv @@
// Self-checking testbench for the RPN stack evaluator: directed token table, then random
// expressions, with results checked against an in-bench stack predictor.
// Depends on rse_pkg, rse_ifs and rpn_stack_evaluator_unit.
`timescale 1ns / 1ps

module rpn_stack_evaluator_unit_tb;
	import rse_pkg::*;

	localparam int unsigned DEPTH          = STACK_DEPTH_DEF;
	localparam int          RANDOM_TOKENS  = 600;
	localparam int          PAUSE_EVERY    = 150;
	localparam int          DRAIN_CYCLES   = 64;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          REPORT_MAX     = 10;

	localparam logic [OPCODE_W-1:0] OPC_RSVD_LO = 3'd5;
	localparam logic [OPCODE_W-1:0] OPC_RSVD_HI = 3'd7;
	localparam logic [DATA_W-1:0]   INT_MIN     = 32'h8000_0000;
	localparam logic [DATA_W-1:0]   INT_MAX     = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0]   MINUS_ONE   = 32'hFFFF_FFFF;

	typedef struct {
		logic [DATA_W-1:0] value;
		status_t           status;
	} res_item_t;

	typedef struct {
		logic [OPCODE_W-1:0] op;
		logic [DATA_W-1:0]   value;
		bit                  last;
		bit                  typed;
		logic [DATA_W-1:0]   t_value;
		status_t             t_status;
	} token_row_t;

	localparam int DIR_ROWS = 24;

	token_row_t dir_rows [DIR_ROWS] = '{
		'{OP_ADD,      32'd0,        1'b1, 1'b1, 32'd0,     STS_UNDERFLOW},
		'{OPC_RSVD_HI, MINUS_ONE,    1'b1, 1'b1, 32'd0,     STS_EMPTY},
		'{OP_PUSH,     MINUS_ONE,    1'b1, 1'b1, MINUS_ONE, STS_OK},
		'{OP_PUSH,     INT_MAX,      1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     32'd1,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_ADD,      32'd0,        1'b1, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     INT_MIN,      1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     MINUS_ONE,    1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_DIV,      32'd0,        1'b1, 1'b1, INT_MIN,   STS_OK},
		'{OP_PUSH,     32'd7,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     32'd0,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_DIV,      INT_MAX,      1'b1, 1'b1, MINUS_ONE, STS_OK},
		'{OP_PUSH,     32'hFFFF_FFF9, 1'b0, 1'b0, 32'd0,    STS_OK},
		'{OP_PUSH,     32'd2,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_DIV,      32'd0,        1'b1, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     INT_MIN,      1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     INT_MAX,      1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_MUL,      32'd0,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OPC_RSVD_LO, 32'd0,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     32'd0,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_SUB,      MINUS_ONE,    1'b1, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     32'd1,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_SUB,      32'd0,        1'b0, 1'b0, 32'd0,     STS_OK},
		'{OP_PUSH,     32'd2,        1'b1, 1'b1, 32'd0,     STS_UNDERFLOW}
	};

	logic clk;
	logic arst_n;

	rse_tok_if token_ch ();
	rse_res_if result_ch ();

	rpn_stack_evaluator_unit #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tok   (token_ch),
		.res   (result_ch)
	);

	logic [DATA_W-1:0] pred_stack [DEPTH];
	int                pred_depth;
	status_t           pred_err;

	res_item_t pending_results [$];
	res_item_t want;
	int        mismatches;
	int        results_seen;
	int        tokens_sent;
	int        burst_left;
	int        idle_cycles;

	int rx_period;
	int rx_duty;
	int rx_left;
	int rx_phase;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one accepted token to the predicted stack; returns 1 when it closes an expression.
	function automatic bit fold_token(input logic [OPCODE_W-1:0] op,
			input logic [DATA_W-1:0] val, input bit last, output res_item_t r);
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] q;
		longint            quo;
		r.value  = '0;
		r.status = STS_OK;
		if (pred_err == STS_OK) begin
			if (op == OP_PUSH) begin
				if (pred_depth >= DEPTH) begin
					pred_err = STS_OVERFLOW;
				end else begin
					pred_stack[pred_depth] = val;
					pred_depth++;
				end
			end else if (op <= OP_DIV) begin
				if (pred_depth < 2) begin
					pred_err = STS_UNDERFLOW;
				end else begin
					b = pred_stack[pred_depth-1];
					a = pred_stack[pred_depth-2];
					case (opcode_t'(op))
						OP_ADD: q = a + b;
						OP_SUB: q = a - b;
						OP_MUL: q = a * b;
						default: begin
							if (b == '0) begin
								q = MINUS_ONE;
							end else begin
								quo = longint'(signed'(a)) / longint'(signed'(b));
								q   = quo[DATA_W-1:0];
							end
						end
					endcase
					pred_depth--;
					pred_stack[pred_depth-1] = q;
				end
			end
		end
		if (!last) return 1'b0;
		if (pred_err != STS_OK) r.status = pred_err;
		else if (pred_depth == 0) r.status = STS_EMPTY;
		else r.value = pred_stack[pred_depth-1];
		pred_depth = 0;
		pred_err   = STS_OK;
		return 1'b1;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 32'd1;
			2:       return MINUS_ONE;
			3:       return INT_MIN;
			4:       return INT_MAX;
			5:       return DATA_W'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_alu_op();
		return OPCODE_W'($urandom_range(int'(OP_ADD), int'(OP_DIV)));
	endfunction

	// Presents one token request, honoring the burst/gap pattern, and waits until it is taken.
	task automatic send_token(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] val,
			input bit last, input bit typed, input logic [DATA_W-1:0] t_value,
			input status_t t_status);
		int        gap;
		res_item_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				token_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		token_ch.valid             <= 1'b1;
		token_ch.opcode            <= op;
		token_ch.number_value      <= val;
		token_ch.end_of_expression <= last;
		do @(posedge clk); while (!token_ch.ready);
		tokens_sent++;
		if (fold_token(op, val, last, r)) begin
			if (typed) begin
				r.value  = t_value;
				r.status = t_status;
			end
			pending_results.insert(pending_results.size(), r);
		end
	endtask

	task automatic wait_drained();
		token_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		burst_left = 0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("unexpected result %0d: value %h status %0d", results_seen,
							result_ch.result_value, result_ch.status);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (result_ch.result_value !== want.value || result_ch.status !== want.status)
							begin
						if (mismatches < REPORT_MAX)
							$display("result %0d: expected value %h status %s, got value %h status %0d",
								results_seen, want.value, want.status.name(),
								result_ch.result_value, result_ch.status);
						mismatches++;
					end
				end
			end
			if (rx_left == 0) begin
				rx_period = $urandom_range(1, 12);
				rx_duty   = ($urandom_range(0, 3) == 0) ? rx_period : $urandom_range(1, rx_period);
				rx_left   = $urandom_range(20, 150);
				rx_phase  = 0;
			end
			rx_left--;
			result_ch.ready <= (rx_phase < rx_duty);
			rx_phase = (rx_phase + 1) % rx_period;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (token_ch.valid && token_ch.ready) || (result_ch.valid && result_ch.ready))
				begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int                  kind;
		int                  steps;
		int                  depth;
		int                  n;
		int                  next_pause;
		logic [OPCODE_W-1:0] op;
		arst_n                     = 1'b0;
		token_ch.valid             = 1'b0;
		token_ch.opcode            = OP_PUSH;
		token_ch.number_value      = '0;
		token_ch.end_of_expression = 1'b0;
		result_ch.ready            = 1'b0;
		pred_depth                 = 0;
		pred_err                   = STS_OK;
		mismatches                 = 0;
		results_seen               = 0;
		tokens_sent                = 0;
		burst_left                 = 0;
		idle_cycles                = 0;
		rx_left                    = 0;
		rx_period                  = 1;
		rx_duty                    = 1;
		rx_phase                   = 0;
		foreach (pred_stack[k]) pred_stack[k] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send_token(dir_rows[k].op, dir_rows[k].value, dir_rows[k].last, dir_rows[k].typed,
				dir_rows[k].t_value, dir_rows[k].t_status);
		wait_drained();

		tokens_sent = 0;
		next_pause  = PAUSE_EVERY;
		while (tokens_sent < RANDOM_TOKENS) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				// Well-formed expression, occasionally deep enough to fill the stack.
				steps = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 34) : $urandom_range(1, 10);
				depth = 0;
				for (int i = 0; i < steps; i++) begin
					if (depth < 2 || (depth < DEPTH && $urandom_range(0, 2) != 0)) begin
						send_token(OP_PUSH, pick_value(), 1'b0, 1'b0, '0, STS_OK);
						depth++;
					end else begin
						send_token(pick_alu_op(), $urandom, 1'b0, 1'b0, '0, STS_OK);
						depth--;
					end
				end
				if ((depth >= 2 && $urandom_range(0, 3) != 0) || depth >= DEPTH)
					send_token(pick_alu_op(), $urandom, 1'b1, 1'b0, '0, STS_OK);
				else
					send_token(OP_PUSH, pick_value(), 1'b1, 1'b0, '0, STS_OK);
			end else if (kind < 16) begin
				n = $urandom_range(DEPTH, DEPTH + 3);
				for (int i = 0; i < n; i++)
					send_token(OP_PUSH, pick_value(), 1'b0, 1'b0, '0, STS_OK);
				op = ($urandom_range(0, 1) == 0) ? OP_PUSH : pick_alu_op();
				send_token(op, pick_value(), 1'b1, 1'b0, '0, STS_OK);
			end else begin
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					send_token(OPCODE_W'($urandom_range(0, int'(OPC_RSVD_HI))), pick_value(), 1'b0,
						1'b0, '0, STS_OK);
				send_token(OPCODE_W'($urandom_range(0, int'(OPC_RSVD_HI))), pick_value(), 1'b1,
					1'b0, '0, STS_OK);
			end
			if (tokens_sent >= next_pause) begin
				wait_drained();
				next_pause += PAUSE_EVERY;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
